// ===== rtl/core/assert_macros.svh =====
// Assertion macros used by the resolver top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_CLK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`define ASSERT_NEVER(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("forbidden condition seen");
`else
`define ASSERT_CLK(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, expr)
`endif
`endif

// ===== rtl/core/pcor_pkg.sv =====
// Package with types and constants of the circle overlap resolver.
`timescale 1ns / 1ps
package pcor_pkg;
    localparam int MaxParticles = 64;
    localparam int FracBits     = 16;
    localparam int IdxW         = $clog2(MaxParticles);
    localparam int CntW         = $clog2(MaxParticles + 1);

    typedef enum logic [3:0] {
        ST_LOAD, ST_RD, ST_RDW, ST_CHK, ST_SQ, ST_MUL, ST_TST, ST_SQRT,
        ST_PROD, ST_DIV, ST_WRI, ST_WRJ, ST_NEXT, ST_EMIT_RD, ST_EMIT_W, ST_EMIT
    } t_state;
endpackage

// ===== rtl/core/pcor_if.sv =====
// Valid/ready channel interfaces for the resolver.
`timescale 1ns / 1ps
interface pcor_in_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic        [30:0] radius;
    logic               last;
    modport source (output valid, pos_x, pos_y, radius, last, input ready);
    modport sink   (input valid, pos_x, pos_y, radius, last, output ready);
endinterface

interface pcor_out_if;
    logic               valid;
    logic               ready;
    logic        [5:0]  index;
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic               final_res;
    modport source (output valid, index, out_x, out_y, final_res, input ready);
    modport sink   (input valid, index, out_x, out_y, final_res, output ready);
endinterface

// ===== rtl/core/pcor_sqrt.sv =====
// Iterative integer square root, one result bit per cycle.
`timescale 1ns / 1ps
module pcor_sqrt (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_val,
    output logic        o_done,
    output logic [31:0] o_root
);
    logic [63:0] r_rem, n_rem;
    logic [31:0] r_root, n_root;
    logic [63:0] r_val;
    logic [5:0]  r_cnt;
    logic        r_busy;
    logic [65:0] w_trial;
    logic [65:0] w_rem2;

    always_comb begin
        w_rem2  = {r_rem, r_val[63:62]};
        w_trial = {32'd0, r_root, 2'b01};
        if (w_rem2 >= w_trial) begin
            n_rem  = 64'(w_rem2 - w_trial);
            n_root = {r_root[30:0], 1'b1};
        end else begin
            n_rem  = w_rem2[63:0];
            n_root = {r_root[30:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 6'd0;
                r_rem  <= 64'd0;
                r_root <= 32'd0;
                r_val  <= i_val;
            end else if (r_busy) begin
                r_rem  <= n_rem;
                r_root <= n_root;
                r_val  <= {r_val[61:0], 2'b00};
                r_cnt  <= r_cnt + 6'd1;
                if (r_cnt == 6'd31) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end
    assign o_root = r_root;
endmodule

// ===== rtl/core/pcor_div.sv =====
// Restoring divider, 64 by 32 bits, one quotient bit per cycle.
`timescale 1ns / 1ps
module pcor_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_num,
    input  logic [31:0] i_den,
    output logic        o_done,
    output logic [63:0] o_quo
);
    logic [63:0] r_q;
    logic [31:0] r_r;
    logic [31:0] r_d;
    logic [6:0]  r_cnt;
    logic        r_busy;
    logic [32:0] w_sh;

    assign w_sh = {r_r, r_q[63]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_q    <= i_num;
                r_r    <= 32'd0;
                r_d    <= i_den;
                r_cnt  <= 7'd0;
            end else if (r_busy) begin
                if (w_sh >= {1'b0, r_d}) begin
                    r_r <= 32'(w_sh - {1'b0, r_d});
                    r_q <= {r_q[62:0], 1'b1};
                end else begin
                    r_r <= w_sh[31:0];
                    r_q <= {r_q[62:0], 1'b0};
                end
                r_cnt <= r_cnt + 7'd1;
                if (r_cnt == 7'd63) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end
    assign o_quo = r_q;
endmodule

// ===== rtl/core/pairwise_circle_overlap_resolver.sv =====
// Top level of the pairwise circle overlap resolver.
`timescale 1ns / 1ps
`include "assert_macros.svh"
// Particles arrive one request per cycle while ready is high and are written
// to slots 0, 1, ... of three one-port-read memories; a request with last set
// is stored too and then starts a pass over every pair (i, j > i), each pair
// seeing the positions that earlier pairs left. A pair reads both entries and
// tests the collision in ST_RD, ST_RDW, ST_CHK, ST_SQ, ST_MUL and, unless a
// component already exceeds the size, ST_TST; a colliding pair goes on through
// the square root, a product step, two divisions and two writes, all on the
// shared iterative units. The positions are then read back and sent in slot
// order through ST_EMIT_RD, ST_EMIT_W and ST_EMIT, which waits on output stalls;
// no request is taken during a pass. Saturated Q15.16 results keep all values on one scale.
module pairwise_circle_overlap_resolver (
    input  logic         i_clk,
    input  logic         i_rst_n,
    pcor_in_if.sink      i_in,
    pcor_out_if.source   o_out
);
    localparam int IW = pcor_pkg::IdxW;
    localparam int CW = pcor_pkg::CntW;

    logic signed [31:0] m_x [pcor_pkg::MaxParticles];
    logic signed [31:0] m_y [pcor_pkg::MaxParticles];
    logic        [30:0] m_s [pcor_pkg::MaxParticles];

    pcor_pkg::t_state r_st, n_st;
    logic [CW-1:0] r_cnt;
    logic [IW-1:0] r_i, r_j, r_addr;
    logic signed [31:0] r_rx, r_ry, r_xi, r_yi;
    logic [30:0] r_rs, r_si;
    logic signed [32:0] r_dx, r_dy;
    logic [31:0] r_ax, r_ay;
    logic r_far;
    logic [63:0] r_sq_ax, r_sq_ay, r_ss;
    logic [31:0] r_len, r_over;
    logic [31:0] r_mx, r_my;
    logic r_divy, r_dgo;
    logic [63:0] r_px, r_py;
    logic signed [31:0] r_xj, r_yj;
    logic w_sq_start, w_sq_done, w_dv_start, w_dv_done;
    logic [31:0] w_root;
    logic [63:0] w_quo;
    logic w_acc, w_wr, w_ov;
    logic [IW-1:0] w_waddr;
    logic signed [31:0] w_wx, w_wy;
    logic [32:0] w_ax, w_ay;
    logic [65:0] w_s2;
    logic [63:0] w_sum;

    function automatic logic signed [31:0] sat(input logic signed [33:0] v);
        if (v > 34'sd2147483647) return 32'h7fffffff;
        if (v < -34'sd2147483648) return 32'h80000000;
        return v[31:0];
    endfunction

    assign w_acc = i_in.valid && i_in.ready;
    assign i_in.ready = (r_st == pcor_pkg::ST_LOAD);

    // Magnitudes of the axis; a component above the size means no contact.
    assign w_ax = r_dx[32] ? 33'(-r_dx) : 33'(r_dx);
    assign w_ay = r_dy[32] ? 33'(-r_dy) : 33'(r_dy);

    // Squared length against squared size; a zero axis is left alone.
    assign w_s2  = 66'(r_sq_ax) + 66'(r_sq_ay);
    assign w_sum = w_s2[63:0];
    assign w_ov  = (w_s2 == 66'd0) || (w_s2 > 66'(r_ss));

    // Memory ports: one write, one read per cycle.
    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            m_x[w_waddr] <= w_wx;
            m_y[w_waddr] <= w_wy;
            if (r_st == pcor_pkg::ST_LOAD) m_s[w_waddr] <= i_in.radius;
        end
        r_rx <= m_x[r_addr];
        r_ry <= m_y[r_addr];
        r_rs <= m_s[r_addr];
    end

    always_comb begin
        w_wr = 1'b0; w_waddr = r_i; w_wx = i_in.pos_x; w_wy = i_in.pos_y;
        unique case (r_st)
            pcor_pkg::ST_LOAD: begin
                w_wr    = w_acc && (r_cnt < CW'(pcor_pkg::MaxParticles));
                w_waddr = r_cnt[IW-1:0];
            end
            pcor_pkg::ST_WRI: begin
                w_wr = 1'b1; w_waddr = r_i;
                w_wx = sat(34'(r_xi) + (r_dx[32] ? -34'(r_mx) : 34'(r_mx)));
                w_wy = sat(34'(r_yi) + (r_dy[32] ? -34'(r_my) : 34'(r_my)));
            end
            pcor_pkg::ST_WRJ: begin
                w_wr = 1'b1; w_waddr = r_j;
                w_wx = sat(34'(r_xj) - (r_dx[32] ? -34'(r_mx) : 34'(r_mx)));
                w_wy = sat(34'(r_yj) - (r_dy[32] ? -34'(r_my) : 34'(r_my)));
            end
            default: ;
        endcase
    end

    always_comb begin
        n_st = r_st;
        unique case (r_st)
            pcor_pkg::ST_LOAD:
                if (w_acc && i_in.last) begin
                    if (r_cnt + CW'(r_cnt < CW'(pcor_pkg::MaxParticles)) > CW'(1))
                        n_st = pcor_pkg::ST_RD;
                    else
                        n_st = pcor_pkg::ST_EMIT_RD;
                end
            pcor_pkg::ST_RD:   n_st = pcor_pkg::ST_RDW;
            pcor_pkg::ST_RDW:  n_st = pcor_pkg::ST_CHK;
            pcor_pkg::ST_CHK:  n_st = pcor_pkg::ST_SQ;
            pcor_pkg::ST_SQ:   n_st = pcor_pkg::ST_MUL;
            pcor_pkg::ST_MUL:  n_st = r_far ? pcor_pkg::ST_NEXT : pcor_pkg::ST_TST;
            pcor_pkg::ST_TST:  n_st = w_ov ? pcor_pkg::ST_NEXT : pcor_pkg::ST_SQRT;
            pcor_pkg::ST_SQRT:
                if (w_sq_done) n_st = (w_root == 32'd0) ? pcor_pkg::ST_NEXT
                                                         : pcor_pkg::ST_PROD;
            pcor_pkg::ST_PROD: n_st = pcor_pkg::ST_DIV;
            pcor_pkg::ST_DIV:  if (w_dv_done && r_divy) n_st = pcor_pkg::ST_WRI;
            pcor_pkg::ST_WRI:  n_st = pcor_pkg::ST_WRJ;
            pcor_pkg::ST_WRJ:  n_st = pcor_pkg::ST_NEXT;
            pcor_pkg::ST_NEXT:
                if (CW'(r_j) + CW'(1) < r_cnt) n_st = pcor_pkg::ST_RD;
                else if (CW'(r_i) + CW'(2) < r_cnt) n_st = pcor_pkg::ST_RD;
                else n_st = pcor_pkg::ST_EMIT_RD;
            pcor_pkg::ST_EMIT_RD: n_st = pcor_pkg::ST_EMIT_W;
            pcor_pkg::ST_EMIT_W:  n_st = pcor_pkg::ST_EMIT;
            pcor_pkg::ST_EMIT:
                if (o_out.ready)
                    n_st = (CW'(r_i) + CW'(1) == r_cnt) ? pcor_pkg::ST_LOAD
                                                         : pcor_pkg::ST_EMIT_RD;
            default: n_st = pcor_pkg::ST_LOAD;
        endcase
    end

    // The divider starts once for x and once for y, each on a one-cycle
    // go flag, so its operands are always settled registers.
    always_comb begin
        w_sq_start      = (r_st == pcor_pkg::ST_TST) && !w_ov;
        w_dv_start      = (r_st == pcor_pkg::ST_DIV) && r_dgo;
        o_out.valid     = (r_st == pcor_pkg::ST_EMIT);
        o_out.index     = 6'(r_i);
        o_out.out_x     = r_rx;
        o_out.out_y     = r_ry;
        o_out.final_res = (CW'(r_i) + CW'(1) == r_cnt);
    end

    pcor_sqrt u_sqrt (.i_clk, .i_rst_n, .i_start(w_sq_start), .i_val(w_sum),
                      .o_done(w_sq_done), .o_root(w_root));
    pcor_div u_div (.i_clk, .i_rst_n, .i_start(w_dv_start),
                    .i_num(r_divy ? r_py : r_px), .i_den(r_len),
                    .o_done(w_dv_done), .o_quo(w_quo));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st  <= pcor_pkg::ST_LOAD;
            r_cnt <= '0;
            r_i   <= '0;
            r_j   <= '0;
        end else begin
            r_st <= n_st;
            unique case (r_st)
                pcor_pkg::ST_LOAD: if (w_acc) begin
                    if (r_cnt < CW'(pcor_pkg::MaxParticles)) r_cnt <= r_cnt + CW'(1);
                    r_i <= '0; r_j <= IW'(1);
                end
                pcor_pkg::ST_NEXT:
                    if (CW'(r_j) + CW'(1) < r_cnt) r_j <= r_j + IW'(1);
                    else if (CW'(r_i) + CW'(2) < r_cnt) begin
                        r_i <= r_i + IW'(1); r_j <= r_i + IW'(2);
                    end else r_i <= '0;
                pcor_pkg::ST_EMIT:
                    if (o_out.ready) begin
                        if (CW'(r_i) + CW'(1) == r_cnt) r_cnt <= '0;
                        else r_i <= r_i + IW'(1);
                    end
                default: ;
            endcase
        end
    end

    // r_addr selects the read: entry i in ST_RD, entry j in ST_RDW.
    always_ff @(posedge i_clk) begin
        unique case (r_st)
            pcor_pkg::ST_LOAD: r_addr <= '0;
            pcor_pkg::ST_RD: r_addr <= r_j;
            pcor_pkg::ST_RDW: begin
                r_xi <= r_rx; r_yi <= r_ry; r_si <= r_rs;
            end
            pcor_pkg::ST_CHK: begin
                r_xj <= r_rx; r_yj <= r_ry;
                r_dx <= 33'(r_xi) - 33'(r_rx);
                r_dy <= 33'(r_yi) - 33'(r_ry);
            end
            pcor_pkg::ST_SQ: begin
                r_ax   <= w_ax[31:0];
                r_ay   <= w_ay[31:0];
                r_far  <= (w_ax > 33'(r_si)) || (w_ay > 33'(r_si));
                r_divy <= 1'b0;
            end
            pcor_pkg::ST_MUL: begin
                r_sq_ax <= 64'(r_ax) * 64'(r_ax);
                r_sq_ay <= 64'(r_ay) * 64'(r_ay);
                r_ss    <= 64'(r_si) * 64'(r_si);
            end
            pcor_pkg::ST_SQRT: if (w_sq_done) begin
                r_len  <= w_root;
                r_over <= {1'b0, r_si} - w_root;
            end
            pcor_pkg::ST_PROD: begin
                r_px  <= 64'(r_over) * 64'(r_ax);
                r_py  <= 64'(r_over) * 64'(r_ay);
                r_dgo <= 1'b1;
            end
            pcor_pkg::ST_DIV:
                if (w_dv_done && !r_divy) begin
                    r_mx <= w_quo[31:0]; r_divy <= 1'b1; r_dgo <= 1'b1;
                end else begin
                    r_dgo <= 1'b0;
                    if (w_dv_done) r_my <= w_quo[31:0];
                end
            pcor_pkg::ST_NEXT:
                if (CW'(r_j) + CW'(1) < r_cnt) r_addr <= r_i;
                else if (CW'(r_i) + CW'(2) < r_cnt) r_addr <= r_i + IW'(1);
                else r_addr <= '0;
            pcor_pkg::ST_EMIT_RD: r_addr <= r_i;
            pcor_pkg::ST_EMIT:
                if (o_out.ready) r_addr <= r_i + IW'(1);
            default: ;
        endcase
    end

    `ASSERT_CLK(a_no_in_in_pass, i_clk, i_rst_n, (r_st != pcor_pkg::ST_LOAD) |-> !i_in.ready)
    `ASSERT_CLK(a_cnt_range, i_clk, i_rst_n, r_cnt <= CW'(pcor_pkg::MaxParticles))
    `ASSERT_NEVER(a_units_excl, i_clk, i_rst_n, w_sq_start && w_dv_start)
endmodule

// ===== bench/tb_pairwise_circle_overlap_resolver.sv =====
// Self-checking testbench of the pairwise circle overlap resolver.
`timescale 1ns / 1ps
module tb_pairwise_circle_overlap_resolver;

    localparam int  CycleLimit = 2000000;
    localparam int  DrainWait  = 40;

    // One resolved position as the output channel carries it.
    typedef struct {
        logic [5:0]         index;
        logic signed [31:0] out_x;
        logic signed [31:0] out_y;
        logic               final_res;
    } t_position;

    // One row of the directed stimulus table; pinned rows carry the
    // position that this particle must come back with.
    typedef struct {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic        [30:0] radius;
        logic               last;
        logic               pinned;
        logic signed [31:0] exp_x;
        logic signed [31:0] exp_y;
    } t_row;

    logic i_clk;
    logic i_rst_n;

    pcor_in_if  in_ch ();
    pcor_out_if out_ch ();

    pairwise_circle_overlap_resolver DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    // Shadow copy of the particle stores.
    longint            shadow_x [pcor_pkg::MaxParticles];
    longint            shadow_y [pcor_pkg::MaxParticles];
    longint unsigned   shadow_sz [pcor_pkg::MaxParticles];
    logic              slot_pinned [pcor_pkg::MaxParticles];
    logic signed [31:0] slot_px [pcor_pkg::MaxParticles];
    logic signed [31:0] slot_py [pcor_pkg::MaxParticles];
    int                shadow_count;

    t_position pending_positions [$];
    int        error_count;
    int        cycle_count;
    int        requests_sent;
    int        sets_sent;
    int        positions_seen;
    int        moved_pairs;
    int        full_drops;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CycleLimit) begin
            $display("tb: failure");
            $finish;
        end
    end

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned res;
        longint unsigned bitv;
        res  = 0;
        bitv = 64'd1 << 62;
        while (bitv > v)
            bitv >>= 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v   = v - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv >>= 2;
        end
        return res;
    endfunction

    function automatic longint clamp32(longint v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    // Pushes one pair apart by the overlap, using the positions that the
    // earlier pairs of the pass left behind.
    task automatic separate_pair(int i, int j);
        longint dx, dy, mx, my;
        longint unsigned ax, ay, sz, sum, len, over;
        dx = shadow_x[i] - shadow_x[j];
        dy = shadow_y[i] - shadow_y[j];
        ax = (dx < 0) ? longint'(-dx) : dx;
        ay = (dy < 0) ? longint'(-dy) : dy;
        sz = shadow_sz[i];
        if (ax > sz || ay > sz)
            return;
        sum = ax * ax + ay * ay;
        if (sum == 0 || sum > sz * sz)
            return;
        len = int_sqrt(sum);
        if (len == 0)
            return;
        over = sz - len;
        mx = longint'((over * ax) / len);
        my = longint'((over * ay) / len);
        if (dx < 0)
            mx = -mx;
        if (dy < 0)
            my = -my;
        if (mx != 0 || my != 0)
            moved_pairs++;
        shadow_x[i] = clamp32(shadow_x[i] + mx);
        shadow_y[i] = clamp32(shadow_y[i] + my);
        shadow_x[j] = clamp32(shadow_x[j] - mx);
        shadow_y[j] = clamp32(shadow_y[j] - my);
    endtask

    // Called once per accepted request, in order: stores the particle if there is
    // room and, on the last one, runs the pass and queues every resolved position.
    task automatic accept_particle(t_row row);
        t_position p;
        if (shadow_count < pcor_pkg::MaxParticles) begin
            shadow_x[shadow_count]    = longint'(row.pos_x);
            shadow_y[shadow_count]    = longint'(row.pos_y);
            shadow_sz[shadow_count]   = row.radius;
            slot_pinned[shadow_count] = row.pinned;
            slot_px[shadow_count]     = row.exp_x;
            slot_py[shadow_count]     = row.exp_y;
            shadow_count++;
        end else begin
            full_drops++;
        end
        requests_sent++;
        if (!row.last)
            return;
        sets_sent++;
        for (int i = 0; i < shadow_count; i++)
            for (int j = i + 1; j < shadow_count; j++)
                separate_pair(i, j);
        for (int i = 0; i < shadow_count; i++) begin
            p.index     = i[5:0];
            p.out_x     = slot_pinned[i] ? slot_px[i] : shadow_x[i][31:0];
            p.out_y     = slot_pinned[i] ? slot_py[i] : shadow_y[i][31:0];
            p.final_res = (i + 1 == shadow_count);
            pending_positions.push_back(p);
        end
        shadow_count = 0;
    endtask

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch %s: got %0d expected %0d at cycle %0d",
                 what, got, want, cycle_count);
        error_count++;
    endtask

    // The result checker samples on the clock edge, before any update of
    // that edge lands, so the order of processes does not matter.
    always @(posedge i_clk) begin
        t_position want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            positions_seen++;
            if (pending_positions.size() == 0) begin
                report_mismatch("unexpected position, index", out_ch.index, -1);
            end else begin
                want = pending_positions.pop_front();
                if (out_ch.index !== want.index)
                    report_mismatch("index", out_ch.index, want.index);
                if (out_ch.out_x !== want.out_x)
                    report_mismatch("out_x", out_ch.out_x, want.out_x);
                if (out_ch.out_y !== want.out_y)
                    report_mismatch("out_y", out_ch.out_y, want.out_y);
                if (out_ch.final_res !== want.final_res)
                    report_mismatch("final_res", out_ch.final_res, want.final_res);
            end
        end
    end

    // The receiver cycles through phases: always ready, coin-flip ready and
    // long stalls, each phase of random length.
    int ready_phase;
    int ready_left;
    always @(posedge i_clk) begin
        if (ready_left == 0) begin
            ready_phase <= $urandom_range(0, 2);
            ready_left  <= $urandom_range(1, 40);
        end else begin
            ready_left <= ready_left - 1;
        end
        case (ready_phase)
            0: begin
                out_ch.ready <= 1'b1;
            end
            1: begin
                out_ch.ready <= 1'($urandom_range(0, 1));
            end
            default: begin
                out_ch.ready <= ($urandom_range(0, 19) == 0);
            end
        endcase
    end

    // The sender works in bursts; between bursts valid drops for a gap.
    int burst_left;
    task automatic send_particle(t_row row);
        in_ch.valid  <= 1'b1;
        in_ch.pos_x  <= row.pos_x;
        in_ch.pos_y  <= row.pos_y;
        in_ch.radius <= row.radius;
        in_ch.last   <= row.last;
        do @(posedge i_clk); while (!in_ch.ready);
        accept_particle(row);
        if (burst_left == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
            burst_left = $urandom_range(0, 15);
        end else begin
            burst_left--;
        end
    endtask

    function automatic t_row make_row(longint x, longint y, longint r, bit last);
        t_row row;
        row.pos_x  = x[31:0];
        row.pos_y  = y[31:0];
        row.radius = r[30:0];
        row.last   = last;
        row.pinned = 1'b0;
        row.exp_x  = '0;
        row.exp_y  = '0;
        return row;
    endfunction

    function automatic t_row pin_row(t_row row);
        row.pinned = 1'b1;
        row.exp_x  = row.pos_x;
        row.exp_y  = row.pos_y;
        return row;
    endfunction

    t_row directed_table [$];

    initial begin
        t_row   row;
        int     n;
        int     kind;
        longint cx, cy, spread, rmax;
        bit     did_full;

        i_rst_n        = 1'b0;
        in_ch.valid    = 1'b0;
        in_ch.pos_x    = '0;
        in_ch.pos_y    = '0;
        in_ch.radius   = '0;
        in_ch.last     = 1'b0;
        out_ch.ready   = 1'b0;
        error_count    = 0;
        cycle_count    = 0;
        requests_sent  = 0;
        sets_sent      = 0;
        positions_seen = 0;
        moved_pairs    = 0;
        full_drops     = 0;
        shadow_count   = 0;
        ready_phase    = 0;
        ready_left     = 0;
        burst_left     = 0;

        // Single particles at the extremes come back unchanged.
        directed_table.push_back(pin_row(make_row(0, 0, 0, 1)));
        directed_table.push_back(pin_row(make_row(64'sd2147483647,
                                  -64'sd2147483648, 64'h7FFF_FFFF, 1)));
        directed_table.push_back(pin_row(make_row(-64'sd2147483648,
                                  64'sd2147483647, 0, 1)));
        // Coincident pair: no axis, so neither moves.
        directed_table.push_back(pin_row(make_row('h10000, 'h20000, 'h50000, 0)));
        directed_table.push_back(pin_row(make_row('h10000, 'h20000, 'h50000, 1)));
        // Far apart along x.
        directed_table.push_back(pin_row(make_row(0, 0, 'h10000, 0)));
        directed_table.push_back(pin_row(make_row('h30000, 0, 0, 1)));
        // Touching exactly at the size: zero overlap, nothing moves.
        directed_table.push_back(pin_row(make_row(0, 0, 'h30000, 0)));
        directed_table.push_back(pin_row(make_row('h30000, 0, 'h30000, 1)));
        // Plain overlap along one axis.
        directed_table.push_back(make_row(0, 0, 'h40000, 0));
        directed_table.push_back(make_row('h10000, 0, 'h10000, 1));
        // Huge size near the positive and negative corners saturates.
        directed_table.push_back(make_row('h7FFF_FFF0, 'h7FFF_FF00, 'h7FFF_FFFF, 0));
        directed_table.push_back(make_row('h7FFF_FF00, 'h7FFF_FFF0, 'h7FFF_FFFF, 1));
        directed_table.push_back(make_row(-64'sd2147483600, -64'sd2147483400,
                                          'h7FFF_FFFF, 0));
        directed_table.push_back(make_row(-64'sd2147483400, -64'sd2147483600,
                                          'h7FFF_FFFF, 1));
        // Diagonal chain of three, where later pairs see earlier moves.
        directed_table.push_back(make_row(0, 0, 'h28000, 0));
        directed_table.push_back(make_row('h10000, 'h10000, 'h28000, 0));
        directed_table.push_back(make_row('h18000, -'h8000, 'h10000, 1));

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_table[k])
            send_particle(directed_table[k]);

        // Random sets: mostly tight clusters that collide, some noise sets
        // with raw fields, and one set that overfills the store.
        did_full = 1'b0;
        while (requests_sent < 330) begin
            kind = $urandom_range(0, 9);
            if (!did_full && requests_sent > 150) begin
                did_full = 1'b1;
                for (int k = 0; k <= pcor_pkg::MaxParticles; k++) begin
                    row = make_row(longint'(k) * 'h100_0000 + $urandom_range(0, 'hFFFF),
                                   $urandom, $urandom_range(0, 'hFFFF),
                                   k == pcor_pkg::MaxParticles);
                    send_particle(row);
                end
            end else if (kind < 7) begin
                n      = $urandom_range(2, 8);
                cx     = longint'($signed($urandom));
                cy     = longint'($signed($urandom));
                spread = longint'(1) << $urandom_range(8, 20);
                rmax   = ($urandom_range(0, 7) == 0) ? 'h7FFF_FFFF : spread * 2;
                for (int k = 0; k < n; k++) begin
                    row = make_row(clamp32(cx + $signed($urandom_range(0, 2 * spread))
                                           - spread),
                                   clamp32(cy + $signed($urandom_range(0, 2 * spread))
                                           - spread),
                                   $urandom_range(0, rmax), k == n - 1);
                    send_particle(row);
                end
            end else begin
                n = $urandom_range(1, 4);
                for (int k = 0; k < n; k++) begin
                    row = make_row(longint'($signed($urandom)),
                                   longint'($signed($urandom)),
                                   $urandom & 32'h7FFF_FFFF, k == n - 1);
                    send_particle(row);
                end
            end
            // Now and then hold the sender until every position is back.
            if ($urandom_range(0, 7) == 0) begin
                in_ch.valid <= 1'b0;
                while (pending_positions.size() != 0)
                    @(posedge i_clk);
                repeat ($urandom_range(1, 10)) @(posedge i_clk);
            end
        end

        in_ch.valid <= 1'b0;
        while (pending_positions.size() != 0)
            @(posedge i_clk);
        repeat (DrainWait) @(posedge i_clk);

        $display("covered %0d particle requests in %0d sets, %0d positions checked",
                 requests_sent, sets_sent, positions_seen);
        $display("pairs pushed apart: %0d, requests dropped on a full store: %0d",
                 moved_pairs, full_drops);
        if (error_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end
endmodule
